[src/olst_pkg.sv]
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants for the ordered list store.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int VALUE_W = 32;
    localparam int OUT_W   = 7;

    typedef enum logic [1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_END   = 2'd1,
        REQ_DELETE    = 2'd2,
        REQ_SEARCH    = 2'd3
    } req_t;

    // request as handed from the front queue to the back sequencer
    typedef struct packed {
        req_t               op;
        logic               needs_scan;
        logic [VALUE_W-1:0] value;
    } olst_cmd_t;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] position;
        logic             rejected_full;
        logic [OUT_W-1:0] entry_count;
    } olst_res_t;

endpackage

[src/ordered_list_store_unit.sv]
// Search compares the stored entries in order from the front, one per cycle
//   through the store's read port, until a match or the end of the list.
// Delete scans the same way, then moves each entry after the match down one offset.
// Throughput: one request at a time in the sequencer; a two-entry request queue
//   and the result register keep both sides taking requests meanwhile.
// Reset: asynchronous, active low; list empty, front index zero, no clearing pass.
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Bounded ordered list of 32-bit values in a ring, with insert, delete, search.
// ----------------------------------------------------------------------------
module ordered_list_store_unit
    import olst_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                req_type,
    input  logic signed [VALUE_W-1:0] item_value,
    output logic                      empty,
    input  logic                      pop,
    output logic                      found,
    output logic [OUT_W-1:0]          position,
    output logic                      rejected_full,
    output logic [OUT_W-1:0]          entry_count
);

    logic      cmd_valid;
    logic      cmd_take;
    olst_cmd_t cmd;
    olst_res_t res;

    olst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .item_value (item_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    olst_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign found         = res.found;
    assign position      = res.position;
    assign rejected_full = res.rejected_full;
    assign entry_count   = res.entry_count;

endmodule

[src/olst_ram.sv]
// ----------------------------------------------------------------------------
// olst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/olst_front.sv]
// ----------------------------------------------------------------------------
// olst_front
// Two-entry request queue; decodes each request as it is taken in.
// ----------------------------------------------------------------------------
module olst_front
    import olst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic [VALUE_W-1:0] item_value,
    output logic               cmd_valid,
    output olst_cmd_t          cmd,
    input  logic               cmd_take
);

    olst_cmd_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push_fire;
    logic       take_fire;
    olst_cmd_t  in_cmd;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign push_fire = push && !full;
    assign take_fire = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.op    = req_t'(req_type);
        in_cmd.value = item_value;
        unique case (req_t'(req_type)) inside
            REQ_DELETE, REQ_SEARCH: in_cmd.needs_scan = 1'b1;
            default:                in_cmd.needs_scan = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_fire ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_fire} - {1'b0, take_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[src/olst_back.sv]
// ----------------------------------------------------------------------------
// olst_back
// Sequencer that runs each request against the ring store and holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module olst_back
    import olst_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  olst_cmd_t cmd,
    output logic      cmd_take,
    input  logic      pop,
    output logic      empty,
    output olst_res_t res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > OUT_W) ? CW : OUT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_RESP} state_t;

    state_t             state_reg, state_next;
    req_t               op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_off_reg, rd_off_next;
    logic [CW-1:0]      wr_off_reg, wr_off_next;
    logic [CW-1:0]      cmp_off_reg, cmp_off_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               rej_reg, rej_next;
    logic               out_valid_reg, out_valid_next;
    olst_res_t          out_reg, out_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               pop_fire;
    logic [AW-1:0]      new_front;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      count_x;

    olst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ring slot of a logical offset from the front
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign empty    = !out_valid_reg;
    assign res      = out_reg;
    assign pop_fire = pop && out_valid_reg;
    assign pos_x    = XW'(pos_reg);
    assign count_x  = XW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rd_off_next    = rd_off_reg;
        wr_off_next    = wr_off_reg;
        cmp_off_next   = cmp_off_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = value_reg;
        ram_raddr      = slot(front_reg, rd_off_reg);
        new_front      = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - AW'(1);

        if (pop_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    op_next    = cmd.op;
                    value_next = cmd.value;
                    found_next = 1'b0;
                    pos_next   = '0;
                    rej_next   = 1'b0;
                    if (cmd.needs_scan)
                    begin
                        rd_off_next = '0;
                        pend_next   = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = cmd.value;
                            count_next = count_reg + CW'(1);
                            if (cmd.op == REQ_INS_FRONT)
                            begin
                                ram_waddr  = new_front;
                                front_next = new_front;
                            end
                            else
                            begin
                                ram_waddr = slot(front_reg, count_reg);
                            end
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && (ram_rdata == value_reg))
                begin
                    found_next = 1'b1;
                    if (op_reg == REQ_DELETE)
                    begin
                        wr_off_next = cmp_off_reg;
                        rd_off_next = cmp_off_reg + CW'(1);
                        pend_next   = 1'b0;   // drop the read still in flight
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        pos_next   = cmp_off_reg + CW'(1);
                        state_next = S_RESP;
                    end
                end
                else if (rd_off_reg < count_reg)
                begin
                    pend_next    = 1'b1;
                    cmp_off_next = rd_off_reg;
                    rd_off_next  = rd_off_reg + CW'(1);
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_SHIFT:
            begin
                // write the entry read from offset i+1 back to offset i while reading the next one
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot(front_reg, wr_off_reg);
                    ram_wdata   = ram_rdata;
                    wr_off_next = wr_off_reg + CW'(1);
                end
                if (rd_off_reg < count_reg)
                begin
                    pend_next   = 1'b1;
                    rd_off_next = rd_off_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            front_next = '0;
                        end
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || pop_fire)
                begin
                    out_valid_next         = 1'b1;
                    out_next.found         = found_reg;
                    out_next.position      = pos_x[OUT_W-1:0];
                    out_next.rejected_full = rej_reg;
                    out_next.entry_count   = count_x[OUT_W-1:0];
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= REQ_INS_FRONT;
            value_reg     <= '0;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_off_reg    <= '0;
            wr_off_reg    <= '0;
            cmp_off_reg   <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            value_reg     <= value_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_off_reg    <= rd_off_next;
            wr_off_reg    <= wr_off_next;
            cmp_off_reg   <= cmp_off_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

[src/olst_checker.sv]
// ----------------------------------------------------------------------------
// olst_checker
// Port-level checks on the ordered list store, bound to the top level.
// ----------------------------------------------------------------------------
module olst_checker
    import olst_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic             found,
    input logic [OUT_W-1:0] position,
    input logic             rejected_full,
    input logic [OUT_W-1:0] entry_count
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && position != '0) |-> found)
        else $error("position given without a match");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected_full) |-> (!found && position == '0))
        else $error("rejected request also reports a match");

    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected_full && CAPACITY < 128) |-> (entry_count == OUT_W'(CAPACITY)))
        else $error("insert rejected while store not full");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped without a pop");

endmodule

bind ordered_list_store_unit olst_checker #(.CAPACITY(CAPACITY)) u_olst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .found         (found),
    .position      (position),
    .rejected_full (rejected_full),
    .entry_count   (entry_count)
);
